@@ rtl/rgb_channel_histogram_core_defines.svh @@
// assertion macros for the histogram core
`ifndef RGB_CHANNEL_HISTOGRAM_CORE_DEFINES_SVH
`define RGB_CHANNEL_HISTOGRAM_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RCH_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("rch assertion failed");
`define RCH_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("rch assertion failed");
`else
`define RCH_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define RCH_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

@@ rtl/rch_pkg.sv @@
package rch_pkg;

    localparam int COUNT_WIDTH      = 24;
    localparam int BINS_PER_CHANNEL = 256;
    localparam int BIN_BITS         = $clog2(BINS_PER_CHANNEL);
    localparam int NUM_LANES        = 3;

    typedef enum logic [1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_NONE  = 2'd3
    } t_chan;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic                rd;
        logic                inc;
        logic                clr;
        logic [BIN_BITS-1:0] bin;
    } t_lane_req;

endpackage

@@ rtl/rgb_channel_histogram_core.sv @@
// a read result passes the lane read register, then the output register
// accumulate and read step from idle to exec (memory read, then update or select)
// a clear never leaves idle; a read waits in exec while the output register is held
// reset: synchronous active low, clears all valid bits at once so every bin reads zero
// no clearing pass is needed after reset or clear
`include "rgb_channel_histogram_core_defines.svh"

module rgb_channel_histogram_core
    import rch_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_command,
    input  logic [7:0]             i_red,
    input  logic [7:0]             i_green,
    input  logic [7:0]             i_blue,
    input  logic [1:0]             i_read_channel,
    input  logic [BIN_BITS-1:0]    i_read_bin,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COUNT_WIDTH-1:0] o_bin_count
);

    t_state                                r_state;
    t_state                                n_state;
    t_cmd                                  r_cmd;
    t_chan                                 r_chan;
    t_cmd                                  w_cmd;
    logic                                  w_take;
    logic                                  w_free;
    logic                                  w_load;
    t_lane_req [NUM_LANES-1:0]             w_req;
    logic [NUM_LANES-1:0][BIN_BITS-1:0]    w_pix;
    logic [NUM_LANES-1:0][COUNT_WIDTH-1:0] w_counts;

    assign w_cmd    = t_cmd'(i_command);
    assign w_pix[0] = i_red;
    assign w_pix[1] = i_green;
    assign w_pix[2] = i_blue;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && (w_cmd == CMD_ACC || w_cmd == CMD_READ)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd != CMD_READ || w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        w_take  = i_valid && o_ready;
        w_load  = (r_state == S_EXEC) && (r_cmd == CMD_READ) && w_free;
        for (int k = 0; k < NUM_LANES; k++) begin
            w_req[k].rd  = w_take && (w_cmd == CMD_ACC || w_cmd == CMD_READ);
            w_req[k].clr = w_take && (w_cmd == CMD_CLEAR);
            w_req[k].inc = (r_state == S_EXEC) && (r_cmd == CMD_ACC);
            w_req[k].bin = (w_cmd == CMD_READ) ? i_read_bin : w_pix[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_NONE;
            r_chan  <= CH_NONE;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_cmd  <= w_cmd;
                r_chan <= t_chan'(i_read_channel);
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rch_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (w_req[g]),
            .o_count (w_counts[g])
        );
    end

    rch_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_chan      (r_chan),
        .i_counts    (w_counts),
        .o_free      (w_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_bin_count (o_bin_count)
    );

    `RCH_ASSERT_NEXT(a_read_enters_exec, i_clk, i_rst_n,
                     w_take && w_cmd == CMD_READ, r_state == S_EXEC)
    `RCH_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, w_load, o_valid)
    `RCH_ASSERT_NEXT(a_read_waits_for_room, i_clk, i_rst_n,
                     r_state == S_EXEC && r_cmd == CMD_READ && !w_free,
                     r_state == S_EXEC && o_valid)
    `RCH_ASSERT_NEXT(a_acc_single_update, i_clk, i_rst_n,
                     r_state == S_EXEC && r_cmd == CMD_ACC, r_state == S_IDLE)

endmodule

@@ rtl/rch_lane.sv @@
module rch_lane
    import rch_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lane_req              i_req,
    output logic [COUNT_WIDTH-1:0] o_count
);

    logic [COUNT_WIDTH-1:0]      r_mem [BINS_PER_CHANNEL];
    logic [BINS_PER_CHANNEL-1:0] r_vld;
    logic [COUNT_WIDTH-1:0]      r_rd_data;
    logic                        r_rd_vld;
    logic [BIN_BITS-1:0]         r_bin;
    logic [COUNT_WIDTH-1:0]      n_count;

    // bins never written since the last clear read as zero
    assign o_count = r_rd_vld ? r_rd_data : '0;
    assign n_count = (o_count == {COUNT_WIDTH{1'b1}}) ? o_count : o_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rd_data <= r_mem[i_req.bin];
            r_bin     <= i_req.bin;
        end
        if (i_req.inc) begin
            r_mem[r_bin] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.inc) begin
                r_vld[r_bin] <= 1'b1;
            end
            if (i_req.rd) begin
                r_rd_vld <= r_vld[i_req.bin];
            end
        end
    end

endmodule

@@ rtl/rch_merge.sv @@
module rch_merge
    import rch_pkg::*;
(
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  t_chan                                 i_chan,
    input  logic [NUM_LANES-1:0][COUNT_WIDTH-1:0] i_counts,
    output logic                                  o_free,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [COUNT_WIDTH-1:0]                o_bin_count
);

    logic                   r_valid;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] w_sel;

    always_comb begin
        case (i_chan)
            CH_RED:   w_sel = i_counts[0];
            CH_GREEN: w_sel = i_counts[1];
            CH_BLUE:  w_sel = i_counts[2];
            default:  w_sel = '0;
        endcase
    end

    assign o_free      = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_bin_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_count <= w_sel;
        end
    end

endmodule

@@ tb/rgb_channel_histogram_checker.sv @@
`timescale 1ns / 1ps

module rgb_channel_histogram_checker
    import rch_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [1:0]             i_command,
    input  logic [7:0]             i_red,
    input  logic [7:0]             i_green,
    input  logic [7:0]             i_blue,
    input  logic [1:0]             i_read_channel,
    input  logic [BIN_BITS-1:0]    i_read_bin,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [COUNT_WIDTH-1:0] i_bin_count,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_reads_checked
);

    logic [COUNT_WIDTH-1:0] hist [NUM_LANES][BINS_PER_CHANNEL];
    logic [COUNT_WIDTH-1:0] count_fifo [$];
    logic [COUNT_WIDTH-1:0] want_count;
    t_cmd                   cmd;
    t_chan                  chan;
    int                     failures = 0;
    int                     checked  = 0;

    function automatic logic [COUNT_WIDTH-1:0] bumped(input logic [COUNT_WIDTH-1:0] c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

    task automatic clear_hist();
        for (int l = 0; l < NUM_LANES; l++) begin
            for (int b = 0; b < BINS_PER_CHANNEL; b++) begin
                hist[l][b] = '0;
            end
        end
    endtask

    task automatic note_failure(input string what, input logic [COUNT_WIDTH-1:0] want,
                                input logic [COUNT_WIDTH-1:0] got);
        if (failures < 10) begin
            $display("%t: %s bin_count expected %0d (0x%06h) actual %0d (0x%06h)",
                     $realtime, what, want, want, got, got);
        end
        failures++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_hist();
            count_fifo.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (count_fifo.size() == 0) begin
                    note_failure("unexpected result beat:", '0, i_bin_count);
                end else begin
                    want_count = count_fifo.pop_front();
                    checked++;
                    if (want_count !== i_bin_count) begin
                        note_failure("read mismatch:", want_count, i_bin_count);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                cmd  = t_cmd'(i_command);
                chan = t_chan'(i_read_channel);
                case (cmd)
                    CMD_ACC: begin
                        hist[CH_RED][i_red]     = bumped(hist[CH_RED][i_red]);
                        hist[CH_GREEN][i_green] = bumped(hist[CH_GREEN][i_green]);
                        hist[CH_BLUE][i_blue]   = bumped(hist[CH_BLUE][i_blue]);
                    end
                    CMD_READ: begin
                        if (chan == CH_NONE) begin
                            count_fifo.push_back('0);
                        end else begin
                            count_fifo.push_back(hist[int'(chan)][i_read_bin]);
                        end
                    end
                    CMD_CLEAR: begin
                        clear_hist();
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count    <= failures;
        o_pending       <= count_fifo.size();
        o_reads_checked <= checked;
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import rch_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_command      = CMD_NONE;
    logic [7:0]             i_red          = '0;
    logic [7:0]             i_green        = '0;
    logic [7:0]             i_blue         = '0;
    logic [1:0]             i_read_channel = CH_RED;
    logic [BIN_BITS-1:0]    i_read_bin     = '0;
    logic                   o_valid;
    logic                   i_ready        = 1'b0;
    logic [COUNT_WIDTH-1:0] o_bin_count;

    int fail_count;
    int pending_count;
    int reads_checked;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_pixels    = 0;
    int n_reads     = 0;
    int n_clears    = 0;
    int n_nops      = 0;

    logic [7:0] hot [4];

    rgb_channel_histogram_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_read_channel (i_read_channel),
        .i_read_bin     (i_read_bin),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bin_count    (o_bin_count)
    );

    rgb_channel_histogram_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_command       (i_command),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_read_channel  (i_read_channel),
        .i_read_bin      (i_read_bin),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_bin_count     (o_bin_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_reads_checked (reads_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_beat(input t_cmd cmd, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input t_chan ch, input logic [7:0] bin);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= b;
        i_read_channel <= ch;
        i_read_bin     <= bin;
        do @(posedge i_clk); while (!o_ready);
        case (cmd)
            CMD_ACC:   n_pixels++;
            CMD_READ:  n_reads++;
            CMD_CLEAR: n_clears++;
            default:   n_nops++;
        endcase
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        send_beat(CMD_ACC, r, g, b, t_chan'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    task automatic send_read(input t_chan ch, input logic [7:0] bin);
        send_beat(CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), ch, bin);
    endtask

    task automatic send_other(input t_cmd cmd);
        send_beat(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), t_chan'($urandom_range(3)),
                  8'($urandom_range(255)));
    endtask

    task automatic refresh_hot();
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(3) == 0) begin
                hot[k] = $urandom_range(1) ? 8'hff : 8'h00;
            end else begin
                hot[k] = 8'($urandom_range(255));
            end
        end
    endtask

    function automatic logic [7:0] pick_value();
        if ($urandom_range(99) < 60) begin
            return hot[2'($urandom_range(3))];
        end
        return 8'($urandom_range(255));
    endfunction

    initial begin
        int counted;
        int roll;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset contents, extremes, back-to-back hits on one bin
        send_read(CH_RED, 8'h00);
        send_read(CH_BLUE, 8'hff);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hff, 8'haa);
        send_read(CH_RED, 8'h00);
        send_read(CH_GREEN, 8'hff);
        send_read(CH_BLUE, 8'haa);
        send_read(CH_GREEN, 8'h00);
        // unused channel and unused command, then reads around clears
        send_read(CH_NONE, 8'h00);
        send_read(CH_NONE, 8'hff);
        send_other(CMD_NONE);
        send_other(CMD_NONE);
        send_read(CH_RED, 8'h00);
        send_other(CMD_CLEAR);
        send_read(CH_RED, 8'h00);
        send_read(CH_BLUE, 8'hff);
        send_pixel(8'h55, 8'h55, 8'h55);
        send_other(CMD_CLEAR);
        send_read(CH_GREEN, 8'h55);
        send_pixel(8'h01, 8'h02, 8'h03);
        send_read(CH_RED, 8'h01);
        send_read(CH_BLUE, 8'h03);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct <= 47;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct <= 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            refresh_hot();
            counted = 0;
            while (counted < 200) begin
                if (counted % 60 == 59) begin
                    refresh_hot();
                end
                roll = $urandom_range(99);
                if (roll < 51) begin
                    send_pixel(pick_value(), pick_value(), pick_value());
                    counted++;
                end else if (roll < 89) begin
                    send_read(t_chan'($urandom_range(2)), pick_value());
                    counted++;
                end else if (roll < 91) begin
                    send_other(CMD_CLEAR);
                    counted++;
                end else if (roll < 96) begin
                    send_other(CMD_NONE);
                end else begin
                    send_read(CH_NONE, 8'($urandom_range(255)));
                    counted++;
                end
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (10) @(posedge i_clk);

        $display("stimulus: %0d pixels, %0d reads, %0d clears, %0d unused commands",
                 n_pixels, n_reads, n_clears, n_nops);
        $display("%0d bin counts compared across three handshake stall profiles",
                 reads_checked);
        if (fail_count == 0) begin
            $display("rgb_channel_histogram_core verification clean");
        end else begin
            $display("rgb_channel_histogram_core verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pending_count);
        $display("rgb_channel_histogram_core verification failed");
        $finish;
    end

endmodule
